[hdl/pointer_gesture_recognizer_macros.svh]
// assertion macros for the pointer gesture recognizer
// expects clk and rst_n in the scope of each use
`ifndef POINTER_GESTURE_RECOGNIZER_MACROS_SVH
`define POINTER_GESTURE_RECOGNIZER_MACROS_SVH

// consequent checked in the same cycle
`define PGR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define PGR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/pgr_pkg.sv]
// shared types, codes and constants of the pointer gesture recognizer
// no dependencies
`default_nettype none
package pgr_pkg;

  localparam int unsigned MAX_POINTERS = 4;
  localparam int unsigned MAX_OUTPUTS  = 8;
  localparam int unsigned SLOT_W = $clog2(MAX_POINTERS);
  localparam int unsigned CNT_W  = $clog2(MAX_POINTERS + 1);
  localparam int unsigned NOUT_W = $clog2(MAX_OUTPUTS + 1);

  // actions
  localparam logic [2:0] ACT_DOWN   = 3'd0;
  localparam logic [2:0] ACT_MOVE   = 3'd1;
  localparam logic [2:0] ACT_UP     = 3'd2;
  localparam logic [2:0] ACT_CANCEL = 3'd3;
  localparam logic [2:0] ACT_WHEEL  = 3'd4;

  // result kinds
  localparam logic [2:0] KIND_PAN_MOVE = 3'd0;
  localparam logic [2:0] KIND_PAN_END  = 3'd1;
  localparam logic [2:0] KIND_TAP      = 3'd2;
  localparam logic [2:0] KIND_TRACK    = 3'd3;
  localparam logic [2:0] KIND_PINCH    = 3'd4;
  localparam logic [2:0] KIND_WHEEL    = 3'd5;

  localparam logic [1:0] STEP_ZERO = 2'b00;
  localparam logic [1:0] STEP_POS  = 2'b01;
  localparam logic [1:0] STEP_NEG  = 2'b11;

  // register indexes
  localparam logic [1:0] CFG_MOVE_THR   = 2'd0;
  localparam logic [1:0] CFG_TAP_WINDOW = 2'd1;
  localparam logic [1:0] CFG_TAP_RADIUS = 2'd2;
  localparam logic [1:0] CFG_PINCH_STEP = 2'd3;

  localparam logic [22:0] MOVE_THR_RST   = 23'd5243;
  localparam logic [15:0] TAP_WINDOW_RST = 16'd300;
  localparam logic [22:0] TAP_RADIUS_RST = 23'd19661;
  localparam logic [15:0] PINCH_STEP_RST = 16'd6554;
  localparam logic [31:0] Q16_ONE        = 32'h0001_0000;

  // squared distance stays below 2^50, so the root search starts at 4^24
  localparam int unsigned SQ_W = 50;
  localparam int unsigned SQRT_TOP_BIT = 48;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PRESS = 2'd1,
    PH_PAN   = 2'd2,
    PH_PINCH = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    SEL_SPREAD = 2'd0,
    SEL_PRESS  = 2'd1,
    SEL_TAP    = 2'd2
  } pt_sel_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_FIND,
    OP_TBL_SET,
    OP_TBL_DEL,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SUM_T,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DOWN_PINCH,
    OP_DOWN_PRESS,
    OP_PUP_MUL,
    OP_PDN_MUL,
    OP_EMIT_PUP,
    OP_EMIT_PDN,
    OP_EMIT_PAN,
    OP_UP_PAN,
    OP_UP_TRACK,
    OP_UP_TAP,
    OP_LEAVE,
    OP_CANCEL_PRIM,
    OP_EMIT_WHEEL,
    OP_FLUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    pt_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] act;
    phase_t     phase;
    logic       hit;
    logic       cnt_ge2;
    logic       is_primary;
    logic       press_valid;
    logic       base_zero;
    logic       root_zero;
    logic       up_ok;
    logic       dn_ok;
    logic       dist_gt;
    logic       tap_time_ok;
    logic       sqrt_last;
    logic       n_full;
    logic       pend_valid;
    logic       out_free;
  } dp_sts_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FIND,
    ST_DISPATCH,
    ST_DOWN_CHK,
    ST_PINCH_CHK,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SUM,
    ST_AFTER,
    ST_SQRT,
    ST_SQRT_DONE,
    ST_PUP_MUL,
    ST_PUP_CMP,
    ST_PDN_MUL,
    ST_PDN_CMP,
    ST_EMIT_PAN,
    ST_UP_CHK,
    ST_EMIT_PANEND,
    ST_EMIT_TAP,
    ST_CANCEL_CHK,
    ST_EMIT_WHEEL,
    ST_FLUSH
  } ctrl_state_t;

endpackage
`default_nettype wire

[hdl/pgr_ctrl.sv]
// sequencer of the pointer gesture recognizer
// depends on pgr_pkg
`default_nettype none
module pgr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pgr_pkg::dp_sts_t  sts,
  output pgr_pkg::dp_cmd_t  cmd
);
  import pgr_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        spread_flow;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // spread is needed by a down and by a move while pinching
  assign spread_flow = (sts.act == ACT_DOWN) ||
                       ((sts.act == ACT_MOVE) && (sts.phase == PH_PINCH));

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    if (spread_flow) begin
      cmd.sel = SEL_SPREAD;
    end else if (sts.act == ACT_MOVE) begin
      cmd.sel = SEL_PRESS;
    end else begin
      cmd.sel = SEL_TAP;
    end
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = ST_FIND;
        end
      end
      ST_FIND: begin
        cmd.op    = OP_FIND;
        state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (sts.act)
          ACT_DOWN: begin
            cmd.op    = OP_TBL_SET;
            state_nxt = ST_DOWN_CHK;
          end
          ACT_MOVE: begin
            if (sts.phase == PH_PINCH) begin
              if (sts.hit) cmd.op = OP_TBL_SET;
              state_nxt = ST_PINCH_CHK;
            end else if (sts.is_primary && sts.press_valid) begin
              state_nxt = (sts.phase == PH_PRESS) ? ST_SQ_X : ST_EMIT_PAN;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          ACT_UP: begin
            cmd.op    = OP_TBL_DEL;
            state_nxt = ST_UP_CHK;
          end
          ACT_CANCEL: begin
            cmd.op    = OP_TBL_DEL;
            state_nxt = ST_CANCEL_CHK;
          end
          ACT_WHEEL: state_nxt = ST_EMIT_WHEEL;
          default:   state_nxt = ST_IDLE;
        endcase
      end
      ST_DOWN_CHK: begin
        if (sts.cnt_ge2) begin
          state_nxt = ST_SQ_X;
        end else begin
          cmd.op    = OP_DOWN_PRESS;
          state_nxt = ST_IDLE;
        end
      end
      ST_PINCH_CHK: begin
        state_nxt = (sts.base_zero || !sts.cnt_ge2) ? ST_IDLE : ST_SQ_X;
      end
      ST_SQ_X: begin
        cmd.op    = OP_SQ_X;
        state_nxt = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        cmd.op    = OP_SQ_Y;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.op    = OP_SUM_T;
        state_nxt = ST_AFTER;
      end
      ST_AFTER: begin
        if (spread_flow) begin
          cmd.op    = OP_SQRT_INIT;
          state_nxt = ST_SQRT;
        end else if (sts.act == ACT_MOVE) begin
          state_nxt = sts.dist_gt ? ST_EMIT_PAN : ST_IDLE;
        end else begin
          state_nxt = ST_EMIT_TAP;
        end
      end
      ST_SQRT: begin
        cmd.op = OP_SQRT_STEP;
        if (sts.sqrt_last) state_nxt = ST_SQRT_DONE;
      end
      ST_SQRT_DONE: begin
        if (sts.act == ACT_DOWN) begin
          cmd.op    = OP_DOWN_PINCH;
          state_nxt = ST_IDLE;
        end else if (sts.root_zero) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.op    = OP_PUP_MUL;
          state_nxt = ST_PUP_CMP;
        end
      end
      ST_PUP_MUL: begin
        cmd.op    = OP_PUP_MUL;
        state_nxt = ST_PUP_CMP;
      end
      ST_PUP_CMP: begin
        if (sts.n_full) begin
          state_nxt = ST_FLUSH;
        end else if (sts.up_ok) begin
          if (sts.out_free) begin
            cmd.op    = OP_EMIT_PUP;
            state_nxt = ST_PUP_MUL;
          end
        end else begin
          cmd.op    = OP_PDN_MUL;
          state_nxt = ST_PDN_CMP;
        end
      end
      ST_PDN_MUL: begin
        cmd.op    = OP_PDN_MUL;
        state_nxt = ST_PDN_CMP;
      end
      ST_PDN_CMP: begin
        if (sts.n_full || !sts.dn_ok) begin
          state_nxt = ST_FLUSH;
        end else if (sts.out_free) begin
          cmd.op    = OP_EMIT_PDN;
          state_nxt = ST_PDN_MUL;
        end
      end
      ST_EMIT_PAN: begin
        if (sts.out_free) begin
          cmd.op    = OP_EMIT_PAN;
          state_nxt = ST_FLUSH;
        end
      end
      ST_UP_CHK: begin
        if (sts.phase == PH_PINCH) begin
          cmd.op    = OP_LEAVE;
          state_nxt = ST_IDLE;
        end else if (sts.is_primary && sts.press_valid) begin
          state_nxt = (sts.phase == PH_PAN) ? ST_EMIT_PANEND : ST_SQ_X;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_PANEND: begin
        if (sts.out_free) begin
          cmd.op    = OP_UP_PAN;
          state_nxt = ST_FLUSH;
        end
      end
      ST_EMIT_TAP: begin
        if (sts.out_free) begin
          cmd.op    = (sts.tap_time_ok && !sts.dist_gt) ? OP_UP_TRACK : OP_UP_TAP;
          state_nxt = ST_FLUSH;
        end
      end
      ST_CANCEL_CHK: begin
        if (sts.phase == PH_PINCH) begin
          cmd.op = OP_LEAVE;
        end else if (sts.is_primary) begin
          cmd.op = OP_CANCEL_PRIM;
        end
        state_nxt = ST_IDLE;
      end
      ST_EMIT_WHEEL: begin
        if (sts.out_free) begin
          cmd.op    = OP_EMIT_WHEEL;
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.op    = OP_FLUSH;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[hdl/pgr_dp.sv]
// datapath of the pointer gesture recognizer: pointer table, gesture state,
// shared multiplier, root unit, pending and output result registers
// depends on pgr_pkg
`default_nettype none
module pgr_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          in_action,
  input  logic [31:0]         in_pointer_id,
  input  logic signed [23:0]  in_pos_x,
  input  logic signed [23:0]  in_pos_y,
  input  logic [31:0]         in_time_ms,
  input  logic                in_wheel_negative,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [22:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_kind,
  output logic signed [23:0]  out_out_x,
  output logic signed [23:0]  out_out_y,
  output logic signed [1:0]   out_step_delta,
  output logic                out_last,
  input  pgr_pkg::dp_cmd_t    cmd,
  output pgr_pkg::dp_sts_t    sts
);
  import pgr_pkg::*;

  // configuration
  logic [22:0] move_thr_r, tap_radius_r;
  logic [15:0] tap_window_r, pinch_step_r;

  // latched word
  logic [2:0]  act_r;
  logic [31:0] id_r, t_r;
  logic [23:0] x_r, y_r;
  logic        wneg_r;

  // pointer table
  logic [31:0] ids_r [MAX_POINTERS];
  logic [23:0] xs_r  [MAX_POINTERS];
  logic [23:0] ys_r  [MAX_POINTERS];
  logic [CNT_W-1:0]  cnt_r;
  logic              hit_r, hit_c;
  logic [SLOT_W-1:0] slot_r, slot_c;

  // gesture state
  phase_t      phase_r;
  logic [31:0] prim_r;
  logic        pv_r, press_valid_r, ptv_r;
  logic [23:0] press_x_r, press_y_r, prior_x_r, prior_y_r;
  logic [31:0] prior_t_r, level_r;
  logic [24:0] base_r;

  // arithmetic
  logic [SQ_W-1:0] acc_r, rem_r, root_r, bit_r;
  logic [57:0]     prod_r;
  logic [32:0]     mul_a;
  logic [24:0]     mul_b;
  logic [23:0]     ax, ay, bx, by;
  logic [24:0]     dx, dy, absx, absy;
  logic [22:0]     thr;
  logic [SQ_W:0]   rb;
  logic [15:0]     step_eff;
  logic [32:0]     nxt_up;
  logic [31:0]     nxt_dn;
  logic [57:0]     cur_sh;

  // results
  logic [NOUT_W-1:0] n_r;
  logic              pend_valid_r, out_valid_r;
  logic [2:0]        pend_kind_r;
  logic [23:0]       pend_x_r, pend_y_r;
  logic [1:0]        pend_d_r;
  logic              emit_en;
  logic [2:0]        emit_kind;
  logic [23:0]       emit_x, emit_y;
  logic [1:0]        emit_d;
  logic              out_free;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    hit_c  = 1'b0;
    slot_c = '0;
    for (int i = MAX_POINTERS - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < cnt_r) && (ids_r[i] == id_r)) begin
        hit_c  = 1'b1;
        slot_c = SLOT_W'(i);
      end
    end
  end

  // operand points for the squared distance
  always_comb begin
    case (cmd.sel)
      SEL_SPREAD: begin
        ax = xs_r[0]; ay = ys_r[0]; bx = xs_r[1]; by = ys_r[1];
      end
      SEL_PRESS: begin
        ax = press_x_r; ay = press_y_r; bx = x_r; by = y_r;
      end
      default: begin
        ax = prior_x_r; ay = prior_y_r; bx = x_r; by = y_r;
      end
    endcase
    thr = (cmd.sel == SEL_TAP) ? tap_radius_r : move_thr_r;
  end

  assign dx   = {ax[23], ax} - {bx[23], bx};
  assign dy   = {ay[23], ay} - {by[23], by};
  assign absx = dx[24] ? (~dx + 25'd1) : dx;
  assign absy = dy[24] ? (~dy + 25'd1) : dy;

  assign step_eff = (pinch_step_r == 16'd0) ? 16'd1 : pinch_step_r;
  assign nxt_up   = {1'b0, level_r} + {17'd0, step_eff};
  assign nxt_dn   = level_r - {16'd0, step_eff};
  assign cur_sh   = {17'd0, root_r[24:0], 16'd0};
  assign rb       = {1'b0, root_r} + {1'b0, bit_r};

  always_comb begin
    case (cmd.op)
      OP_SQ_X:    begin mul_a = {8'd0, absx};        mul_b = absx;          end
      OP_SQ_Y:    begin mul_a = {8'd0, absy};        mul_b = absy;          end
      OP_SUM_T:   begin mul_a = {10'd0, thr};        mul_b = {2'd0, thr};   end
      OP_PUP_MUL: begin mul_a = nxt_up;              mul_b = base_r;        end
      OP_PDN_MUL: begin mul_a = {1'b0, nxt_dn};      mul_b = base_r;        end
      default:    begin mul_a = '0;                  mul_b = '0;            end
    endcase
  end

  // result placed in the pending register by this op
  always_comb begin
    emit_en   = 1'b1;
    emit_kind = KIND_PAN_MOVE;
    emit_x    = x_r;
    emit_y    = y_r;
    emit_d    = STEP_ZERO;
    case (cmd.op)
      OP_EMIT_PAN: emit_kind = KIND_PAN_MOVE;
      OP_UP_PAN:   emit_kind = KIND_PAN_END;
      OP_UP_TRACK: emit_kind = KIND_TRACK;
      OP_UP_TAP:   emit_kind = KIND_TAP;
      OP_EMIT_PUP, OP_EMIT_PDN, OP_EMIT_WHEEL: begin
        emit_kind = (cmd.op == OP_EMIT_WHEEL) ? KIND_WHEEL : KIND_PINCH;
        emit_x    = '0;
        emit_y    = '0;
        if (cmd.op == OP_EMIT_PUP) begin
          emit_d = STEP_POS;
        end else if (cmd.op == OP_EMIT_PDN) begin
          emit_d = STEP_NEG;
        end else begin
          emit_d = wneg_r ? STEP_POS : STEP_NEG;
        end
      end
      default: emit_en = 1'b0;
    endcase
  end

  always_comb begin
    sts.act         = act_r;
    sts.phase       = phase_r;
    sts.hit         = hit_r;
    sts.cnt_ge2     = cnt_r >= CNT_W'(2);
    sts.is_primary  = pv_r && (id_r == prim_r);
    sts.press_valid = press_valid_r;
    sts.base_zero   = base_r == '0;
    sts.root_zero   = root_r == '0;
    sts.up_ok       = !nxt_up[32] && (cur_sh >= prod_r);
    sts.dn_ok       = (level_r > {16'd0, step_eff}) && (cur_sh <= prod_r);
    sts.dist_gt     = {8'd0, acc_r} > prod_r;
    sts.tap_time_ok = ptv_r && ((t_r - prior_t_r) <= {16'd0, tap_window_r});
    sts.sqrt_last   = bit_r[0];
    sts.n_full      = n_r == NOUT_W'(MAX_OUTPUTS);
    sts.pend_valid  = pend_valid_r;
    sts.out_free    = out_free;
  end

  // control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_thr_r    <= MOVE_THR_RST;
      tap_window_r  <= TAP_WINDOW_RST;
      tap_radius_r  <= TAP_RADIUS_RST;
      pinch_step_r  <= PINCH_STEP_RST;
      cnt_r         <= '0;
      phase_r       <= PH_IDLE;
      prim_r        <= '0;
      pv_r          <= 1'b0;
      press_valid_r <= 1'b0;
      press_x_r     <= '0;
      press_y_r     <= '0;
      base_r        <= '0;
      level_r       <= Q16_ONE;
      ptv_r         <= 1'b0;
      prior_x_r     <= '0;
      prior_y_r     <= '0;
      prior_t_r     <= '0;
      n_r           <= '0;
      pend_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_MOVE_THR:   move_thr_r   <= cfg_data;
          CFG_TAP_WINDOW: tap_window_r <= cfg_data[15:0];
          CFG_TAP_RADIUS: tap_radius_r <= cfg_data;
          CFG_PINCH_STEP: pinch_step_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      // output register loads on a push from pending, else drains on ready
      if ((emit_en && pend_valid_r) || (cmd.op == OP_FLUSH)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (emit_en) begin
        pend_valid_r <= 1'b1;
        n_r          <= n_r + NOUT_W'(1);
      end
      case (cmd.op)
        OP_LATCH: n_r <= '0;
        OP_TBL_SET: if (!hit_r && (cnt_r < CNT_W'(MAX_POINTERS))) cnt_r <= cnt_r + CNT_W'(1);
        OP_TBL_DEL: if (hit_r) cnt_r <= cnt_r - CNT_W'(1);
        OP_DOWN_PINCH: begin
          phase_r       <= PH_PINCH;
          pv_r          <= 1'b0;
          press_valid_r <= 1'b0;
          base_r        <= root_r[24:0];
          level_r       <= Q16_ONE;
        end
        OP_DOWN_PRESS: begin
          phase_r       <= PH_PRESS;
          prim_r        <= id_r;
          pv_r          <= 1'b1;
          press_valid_r <= 1'b1;
          press_x_r     <= x_r;
          press_y_r     <= y_r;
        end
        OP_EMIT_PUP: level_r <= nxt_up[31:0];
        OP_EMIT_PDN: level_r <= nxt_dn;
        OP_EMIT_PAN: phase_r <= PH_PAN;
        OP_UP_PAN, OP_UP_TRACK, OP_CANCEL_PRIM: begin
          phase_r       <= PH_IDLE;
          pv_r          <= 1'b0;
          press_valid_r <= 1'b0;
          if (cmd.op != OP_CANCEL_PRIM) ptv_r <= 1'b0;
        end
        OP_UP_TAP: begin
          phase_r       <= PH_IDLE;
          pv_r          <= 1'b0;
          press_valid_r <= 1'b0;
          ptv_r         <= 1'b1;
          prior_x_r     <= x_r;
          prior_y_r     <= y_r;
          prior_t_r     <= t_r;
        end
        OP_LEAVE: begin
          if (cnt_r < CNT_W'(2)) begin
            phase_r <= PH_IDLE;
            pv_r    <= 1'b0;
            base_r  <= '0;
          end
        end
        OP_FLUSH: pend_valid_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LATCH) begin
      act_r  <= in_action;
      id_r   <= in_pointer_id;
      x_r    <= in_pos_x;
      y_r    <= in_pos_y;
      t_r    <= in_time_ms;
      wneg_r <= in_wheel_negative;
    end
    if (cmd.op == OP_FIND) begin
      hit_r  <= hit_c;
      slot_r <= slot_c;
    end
    if (cmd.op == OP_TBL_SET) begin
      if (hit_r) begin
        ids_r[slot_r] <= id_r;
        xs_r[slot_r]  <= x_r;
        ys_r[slot_r]  <= y_r;
      end else if (cnt_r < CNT_W'(MAX_POINTERS)) begin
        ids_r[cnt_r[SLOT_W-1:0]] <= id_r;
        xs_r[cnt_r[SLOT_W-1:0]]  <= x_r;
        ys_r[cnt_r[SLOT_W-1:0]]  <= y_r;
      end
    end
    if (cmd.op == OP_TBL_DEL && hit_r) begin
      for (int i = 0; i < MAX_POINTERS - 1; i++) begin
        if ((SLOT_W'(i) >= slot_r) && (CNT_W'(i + 1) < cnt_r)) begin
          ids_r[i] <= ids_r[i + 1];
          xs_r[i]  <= xs_r[i + 1];
          ys_r[i]  <= ys_r[i + 1];
        end
      end
    end
    case (cmd.op)
      OP_SQ_X, OP_PUP_MUL, OP_PDN_MUL: prod_r <= mul_a * mul_b;
      OP_SQ_Y: begin
        acc_r  <= prod_r[SQ_W-1:0];
        prod_r <= mul_a * mul_b;
      end
      OP_SUM_T: begin
        acc_r  <= acc_r + prod_r[SQ_W-1:0];
        prod_r <= mul_a * mul_b;
      end
      OP_SQRT_INIT: begin
        rem_r  <= acc_r;
        root_r <= '0;
        bit_r  <= SQ_W'(1) << SQRT_TOP_BIT;
      end
      OP_SQRT_STEP: begin
        if ({1'b0, rem_r} >= rb) begin
          rem_r  <= rem_r - rb[SQ_W-1:0];
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      default: ;
    endcase
    if (emit_en) begin
      if (pend_valid_r) begin
        out_kind       <= pend_kind_r;
        out_out_x      <= pend_x_r;
        out_out_y      <= pend_y_r;
        out_step_delta <= pend_d_r;
        out_last       <= 1'b0;
      end
      pend_kind_r <= emit_kind;
      pend_x_r    <= emit_x;
      pend_y_r    <= emit_y;
      pend_d_r    <= emit_d;
    end
    if (cmd.op == OP_FLUSH) begin
      out_kind       <= pend_kind_r;
      out_out_x      <= pend_x_r;
      out_out_y      <= pend_y_r;
      out_step_delta <= pend_d_r;
      out_last       <= 1'b1;
    end
  end

endmodule
`default_nettype wire

[hdl/pointer_gesture_recognizer.sv]
// top level of the pointer gesture recognizer
// depends on pgr_pkg, pgr_ctrl, pgr_dp and pointer_gesture_recognizer_macros.svh
//
//  channel  direction  handshake          word
//  in_      input      in_valid/ready     action, id, position, time, wheel sign
//  out_     output     out_valid/ready    kind, position, step, last marker
//  cfg_     input      cfg_valid/ready    register index and data
//
// the longest items are pinch events that compute the spread; the 25-step root
// unit and the pinch step loop, a multiply state and a compare state per step,
// set their length
// reset is synchronous on rst_n; table entries are not cleared, only the count
// a new word is taken once the last result sits in the output register;
// a stalled output holds the sequencer at the next result
`default_nettype none
module pointer_gesture_recognizer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_action,
  input  logic [31:0]        in_pointer_id,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic [31:0]        in_time_ms,
  input  logic               in_wheel_negative,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_kind,
  output logic signed [23:0] out_out_x,
  output logic signed [23:0] out_out_y,
  output logic signed [1:0]  out_step_delta,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [22:0]        cfg_data
);
  import pgr_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    result_op;

  pgr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pgr_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_action         (in_action),
    .in_pointer_id     (in_pointer_id),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_time_ms        (in_time_ms),
    .in_wheel_negative (in_wheel_negative),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_out_x         (out_out_x),
    .out_out_y         (out_out_y),
    .out_step_delta    (out_step_delta),
    .out_last          (out_last),
    .cmd               (cmd),
    .sts               (sts)
  );

  // ops that write a result toward the output register
  assign result_op = (cmd.op == OP_EMIT_PAN) || (cmd.op == OP_EMIT_PUP) ||
                     (cmd.op == OP_EMIT_PDN) || (cmd.op == OP_UP_PAN) ||
                     (cmd.op == OP_UP_TAP) || (cmd.op == OP_UP_TRACK) ||
                     (cmd.op == OP_EMIT_WHEEL) || (cmd.op == OP_FLUSH);

`include "pointer_gesture_recognizer_macros.svh"

  // no result of the previous word may linger when a new one is taken
  `PGR_ASSERT_SAME(a_no_stale_pending, in_ready, !sts.pend_valid, "pending result at accept")

  // results only move into the output register when it has room
  `PGR_ASSERT_SAME(a_emit_has_room, result_op, sts.out_free, "result into full output register")

  // an accepted word is looked up in the table next
  `PGR_ASSERT_NEXT(a_lookup_after_accept, in_valid && in_ready, cmd.op == OP_FIND, "no table lookup after accept")

endmodule
`default_nettype wire
